@@ src/ntt_pkg.sv @@
// Shared types and codes for the neighbor table with TTL aging.
package ntt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_FIND    = 2'd1,
        CMD_CLEANUP = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEANUP   = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_seconds;
        logic [47:0] sender_mac;
        logic [7:0]  chassis_subtype;
        logic [63:0] chassis_bytes;
        logic [7:0]  chassis_length;
        logic [7:0]  port_subtype;
        logic [63:0] port_bytes;
        logic [7:0]  port_length;
        logic [15:0] ttl_in_seconds;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_index;
        logic [47:0] found_mac;
        logic [15:0] found_ttl;
        logic [31:0] found_expiry;
        logic [5:0]  removed_count;
        logic [5:0]  neighbor_count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input item, clear scan state
        logic rd;        // issue read at scan pointer
        logic eval;      // evaluate read data for the current entry
        logic wr_entry;  // write key/data to selected slot
        logic finish;    // form result into output register
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic last;      // scan pointer at last slot
        logic too_long;  // captured id length out of range
        logic hit;       // match found so far
    } t_stat;

endpackage

@@ src/neighbor_table_with_ttl_aging.sv @@
// Neighbor table with TTL aging. Every item walks all TABLE_DEPTH slots, each
// slot in two steps (registered memory read, then compare), and the result is
// then formed into an output register. An add or find with an id length out of
// range skips the walk. The result must be taken before the next item is
// accepted, so a stalled result holds the input off.
module neighbor_table_with_ttl_aging #(
    parameter int TABLE_DEPTH = 32,
    parameter int ID_BYTES    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ntt_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ntt_pkg::t_out_item o_item
);
    ntt_pkg::t_ctrl w_ctrl;
    ntt_pkg::t_stat w_stat;

    ntt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready_in  (o_ready),
        .o_valid_out (o_valid),
        .i_ready_out (i_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    ntt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BYTES    (ID_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_result (o_item)
    );

endmodule

@@ src/ntt_datapath.sv @@
// Datapath: entry memory, valid bits, scan pointer, match and result logic.
module ntt_datapath #(
    parameter int TABLE_DEPTH = 32,
    parameter int ID_BYTES    = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntt_pkg::t_in_item i_item,
    input  ntt_pkg::t_ctrl    i_ctrl,
    output ntt_pkg::t_stat    o_stat,
    output ntt_pkg::t_out_item o_result
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  cs;
        logic [63:0] cid;
        logic [3:0]  clen;
        logic [7:0]  ps;
        logic [63:0] pid;
        logic [3:0]  plen;
        logic [15:0] ttl;
        logic [31:0] expiry;
    } t_entry;

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rdata;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     r_rd_idx;
    ntt_pkg::t_in_item r_in;
    t_entry            r_key;
    logic              r_too_long;
    logic              r_hit;
    logic              r_free_ok;
    logic [AW-1:0]     r_hit_idx;
    logic [AW-1:0]     r_free_idx;
    logic [CW-1:0]     r_total;
    logic [CW-1:0]     r_removed;

    logic [63:0] w_cmask;
    logic [63:0] w_pmask;
    logic        w_match;
    logic        w_due;
    logic        w_wr;
    logic [AW-1:0] w_sel;

    function automatic logic [63:0] f_mask(input logic [7:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < int'(len)) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    assign w_cmask = f_mask(i_item.chassis_length);
    assign w_pmask = f_mask(i_item.port_length);

    assign w_match = r_valid[r_rd_idx] && r_rdata.cs == r_key.cs
        && r_rdata.clen == r_key.clen && r_rdata.cid == r_key.cid
        && r_rdata.ps == r_key.ps && r_rdata.plen == r_key.plen
        && r_rdata.pid == r_key.pid;
    assign w_due = r_valid[r_rd_idx] && (r_in.now_seconds >= r_rdata.expiry);

    assign w_sel = r_hit ? r_hit_idx : r_free_idx;

    // find and the unused command walk the table but never write it
    assign w_wr = i_ctrl.wr_entry && (r_in.command == ntt_pkg::CMD_ADD);

    assign o_stat.last     = (r_ptr == AW'(TABLE_DEPTH - 1));
    assign o_stat.too_long = r_too_long;
    assign o_stat.hit      = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_total   <= '0;
            r_ptr     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_removed <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_in       <= i_item;
                // length limit applies to add and find only
                r_too_long <= ((i_item.command == ntt_pkg::CMD_ADD)
                               || (i_item.command == ntt_pkg::CMD_FIND))
                           && ((i_item.chassis_length > 8'(ID_BYTES))
                               || (i_item.port_length > 8'(ID_BYTES)));
                r_key.mac  <= i_item.sender_mac;
                r_key.cs   <= i_item.chassis_subtype;
                r_key.cid  <= i_item.chassis_bytes & w_cmask;
                r_key.clen <= i_item.chassis_length[3:0];
                r_key.ps   <= i_item.port_subtype;
                r_key.pid  <= i_item.port_bytes & w_pmask;
                r_key.plen <= i_item.port_length[3:0];
                r_key.ttl  <= i_item.ttl_in_seconds;
                r_key.expiry <= i_item.now_seconds + {16'd0, i_item.ttl_in_seconds};
                r_ptr      <= '0;
                r_hit      <= 1'b0;
                r_free_ok  <= 1'b0;
                r_removed  <= '0;
            end
            if (i_ctrl.rd) begin
                r_rdata  <= r_mem[r_ptr];
                r_rd_idx <= r_ptr;
                if (!o_stat.last) r_ptr <= r_ptr + 1'b1;
            end
            if (i_ctrl.eval) begin
                if (r_in.command == ntt_pkg::CMD_CLEANUP) begin
                    if (w_due) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_removed <= r_removed + 1'b1;
                        r_total   <= r_total - 1'b1;
                    end
                end else begin
                    if (w_match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                    end
                    if (!r_valid[r_rd_idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                end
            end
            if (w_wr && !r_hit && r_free_ok) begin
                r_valid[r_free_idx] <= 1'b1;
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && (r_hit || r_free_ok)) begin
            r_mem[w_sel] <= r_key;
        end
    end

    // Result register; memory read data of the hit slot comes from r_rdata
    // only for find, the key itself for add.
    t_entry r_found;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval && w_match && !r_hit) r_found <= r_rdata;
    end

    ntt_pkg::t_out_item n_result;
    always_comb begin
        n_result = '0;
        n_result.neighbor_count = 6'(r_total);
        unique case (ntt_pkg::t_cmd'(r_in.command))
            ntt_pkg::CMD_CLEANUP: begin
                n_result.status        = ntt_pkg::ST_CLEANUP;
                n_result.removed_count = 6'(r_removed);
            end
            ntt_pkg::CMD_ADD: begin
                if (r_too_long) begin
                    n_result.status = ntt_pkg::ST_TOO_LONG;
                end else if (r_hit || r_free_ok) begin
                    n_result.status       = r_hit ? ntt_pkg::ST_UPDATED
                                                  : ntt_pkg::ST_ADDED;
                    n_result.slot_index   = 5'(w_sel);
                    n_result.found_mac    = r_key.mac;
                    n_result.found_ttl    = r_key.ttl;
                    n_result.found_expiry = r_key.expiry;
                end else begin
                    n_result.status = ntt_pkg::ST_FULL;
                end
            end
            ntt_pkg::CMD_FIND: begin
                if (r_too_long) begin
                    n_result.status = ntt_pkg::ST_TOO_LONG;
                end else if (r_hit) begin
                    n_result.status       = ntt_pkg::ST_FOUND;
                    n_result.slot_index   = 5'(r_hit_idx);
                    n_result.found_mac    = r_found.mac;
                    n_result.found_ttl    = r_found.ttl;
                    n_result.found_expiry = r_found.expiry;
                end else begin
                    n_result.status = ntt_pkg::ST_NOT_FOUND;
                end
            end
            default: n_result.status = ntt_pkg::ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result <= '0;
        end else if (i_ctrl.finish) begin
            o_result <= n_result;
        end
    end

endmodule

@@ src/ntt_ctrl.sv @@
// Controller: sequences the table scan and the handshakes.
module ntt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready_in,
    output logic           o_valid_out,
    input  logic           i_ready_out,
    input  ntt_pkg::t_stat i_stat,
    output ntt_pkg::t_ctrl o_ctrl
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_READ, S_EVAL, S_WRITE, S_DONE, S_OUT
    } t_state;

    t_state r_state;
    logic   r_last_rd;
    logic   r_out_valid;

    assign o_ready_in  = (r_state == S_IDLE);
    assign o_valid_out = r_out_valid;

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.load     = (r_state == S_IDLE) && i_valid;
        o_ctrl.rd       = (r_state == S_READ);
        o_ctrl.eval     = (r_state == S_EVAL);
        o_ctrl.wr_entry = (r_state == S_WRITE);
        o_ctrl.finish   = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_rd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_CHECK;
                S_CHECK: r_state <= i_stat.too_long ? S_DONE : S_READ;
                S_READ: begin
                    r_last_rd <= i_stat.last;
                    r_state   <= S_EVAL;
                end
                S_EVAL:  r_state <= r_last_rd ? S_WRITE : S_READ;
                S_WRITE: r_state <= S_DONE;
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: if (i_ready_out) begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/ntt_checker.sv @@
// Port-level checker for the neighbor table, bound to the top level.
module ntt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input ntt_pkg::t_out_item o_item
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken right after an accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.neighbor_count <= 6'd32)
        else $error("neighbor count out of range");

    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != ntt_pkg::ST_CLEANUP |-> o_item.removed_count == 6'd0)
        else $error("removed count outside cleanup");
endmodule

bind neighbor_table_with_ttl_aging ntt_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

@@ dv/neighbor_table_with_ttl_aging_tb.sv @@
// Self-checking testbench for the neighbor table with TTL aging.
`timescale 1ns / 1ps

module neighbor_table_with_ttl_aging_tb;

    localparam int DEPTH    = 32;
    localparam int ID_MAX   = 8;
    localparam int KEY_POOL = 44;

    typedef struct {
        logic [7:0]  cs;
        logic [63:0] cid;
        logic [7:0]  clen;
        logic [7:0]  ps;
        logic [63:0] pid;
        logic [7:0]  plen;
    } t_key;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    ntt_pkg::t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    ntt_pkg::t_out_item o_item;

    neighbor_table_with_ttl_aging dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the neighbor table
    logic        nb_valid  [DEPTH];
    logic [47:0] nb_mac    [DEPTH];
    logic [7:0]  nb_cs     [DEPTH];
    logic [63:0] nb_cid    [DEPTH];
    logic [7:0]  nb_clen   [DEPTH];
    logic [7:0]  nb_ps     [DEPTH];
    logic [63:0] nb_pid    [DEPTH];
    logic [7:0]  nb_plen   [DEPTH];
    logic [15:0] nb_ttl    [DEPTH];
    logic [31:0] nb_expiry [DEPTH];
    int          nb_total;

    ntt_pkg::t_out_item pending_results[$];
    t_key        keys[KEY_POOL];
    logic [31:0] now_s;
    bit          quiet = 1'b0;
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    int          n_removed = 0;
    int          n_full = 0;
    int          n_found = 0;

    function automatic logic [63:0] id_mask(input logic [7:0] len);
        if (len >= 8) return '1;
        return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    function automatic ntt_pkg::t_out_item table_step(input ntt_pkg::t_in_item it);
        ntt_pkg::t_out_item r;
        int          hit;
        logic [63:0] cid;
        logic [63:0] pid;
        r   = '0;
        hit = -1;
        r.status = ntt_pkg::ST_NOT_FOUND;
        if (it.command == ntt_pkg::CMD_CLEANUP) begin
            for (int i = 0; i < DEPTH; i++)
                if (nb_valid[i] && it.now_seconds >= nb_expiry[i]) begin
                    nb_valid[i] = 1'b0;
                    nb_total--;
                    r.removed_count++;
                end
            n_removed += r.removed_count;
            r.status = ntt_pkg::ST_CLEANUP;
        end else if (it.command == ntt_pkg::CMD_ADD || it.command == ntt_pkg::CMD_FIND) begin
            if (it.chassis_length > ID_MAX || it.port_length > ID_MAX) begin
                r.status = ntt_pkg::ST_TOO_LONG;
            end else begin
                cid = it.chassis_bytes & id_mask(it.chassis_length);
                pid = it.port_bytes & id_mask(it.port_length);
                for (int i = 0; i < DEPTH; i++)
                    if (hit < 0 && nb_valid[i] && nb_cs[i] == it.chassis_subtype &&
                        nb_clen[i] == it.chassis_length && nb_cid[i] == cid &&
                        nb_ps[i] == it.port_subtype && nb_plen[i] == it.port_length &&
                        nb_pid[i] == pid)
                        hit = i;
                if (it.command == ntt_pkg::CMD_FIND) begin
                    r.status = (hit >= 0) ? ntt_pkg::ST_FOUND : ntt_pkg::ST_NOT_FOUND;
                    if (hit >= 0) n_found++;
                end else begin
                    if (hit >= 0) begin
                        r.status = ntt_pkg::ST_UPDATED;
                    end else begin
                        for (int i = 0; i < DEPTH; i++)
                            if (hit < 0 && !nb_valid[i]) hit = i;
                        if (hit >= 0) begin
                            r.status     = ntt_pkg::ST_ADDED;
                            nb_valid[hit] = 1'b1;
                            nb_total++;
                        end else begin
                            r.status = ntt_pkg::ST_FULL;
                            n_full++;
                        end
                    end
                    if (hit >= 0) begin
                        nb_mac[hit]    = it.sender_mac;
                        nb_cs[hit]     = it.chassis_subtype;
                        nb_cid[hit]    = cid;
                        nb_clen[hit]   = it.chassis_length;
                        nb_ps[hit]     = it.port_subtype;
                        nb_pid[hit]    = pid;
                        nb_plen[hit]   = it.port_length;
                        nb_ttl[hit]    = it.ttl_in_seconds;
                        nb_expiry[hit] = it.now_seconds + 32'(it.ttl_in_seconds);
                    end
                end
            end
        end
        if (hit >= 0) begin
            r.slot_index   = hit[4:0];
            r.found_mac    = nb_mac[hit];
            r.found_ttl    = nb_ttl[hit];
            r.found_expiry = nb_expiry[hit];
        end
        r.neighbor_count = nb_total[5:0];
        return r;
    endfunction

    task automatic send_item(input ntt_pkg::t_in_item it);
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(table_step(it));
        n_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        // drop valid first so the last item is not taken a second time
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic ntt_pkg::t_in_item make_item(input ntt_pkg::t_cmd cmd,
                                                    input t_key k,
                                                    input logic [15:0] ttl);
        ntt_pkg::t_in_item it;
        it.command         = cmd;
        it.now_seconds     = now_s;
        it.sender_mac      = 48'({$urandom, $urandom});
        it.chassis_subtype = k.cs;
        it.chassis_bytes   = k.cid;
        it.chassis_length  = k.clen;
        it.port_subtype    = k.ps;
        it.port_bytes      = k.pid;
        it.port_length     = k.plen;
        it.ttl_in_seconds  = ttl;
        return it;
    endfunction

    function automatic t_key rand_key(input int max_len);
        t_key k;
        k.cs   = 8'($urandom);
        k.cid  = {$urandom, $urandom};
        k.clen = 8'($urandom_range(0, max_len));
        k.ps   = 8'($urandom);
        k.pid  = {$urandom, $urandom};
        k.plen = 8'($urandom_range(0, max_len));
        return k;
    endfunction

    // extremes, every command, masking of bytes past the length, long ids
    task automatic test_directed();
        t_key     k;
        t_key     kj;
        ntt_pkg::t_in_item it;
        now_s  = 32'hFFFF_FFF0;
        k.cs   = 8'hFF; k.cid = '1; k.clen = 8'd8; k.ps = 8'hFF; k.pid = '1; k.plen = 8'd8;
        send_item(make_item(ntt_pkg::CMD_ADD, k, 16'hFFFF));   // expiry wraps
        send_item(make_item(ntt_pkg::CMD_FIND, k, 16'd0));
        it = make_item(ntt_pkg::CMD_ADD, k, 16'd5);
        it.sender_mac = '1;
        send_item(it);                                // update
        k.cs = '0; k.cid = '0; k.clen = '0; k.ps = '0; k.pid = '0; k.plen = '0;
        it = make_item(ntt_pkg::CMD_ADD, k, 16'd0);
        it.sender_mac = '0;
        send_item(it);
        // same key with junk above the length must match
        kj = k; kj.clen = 8'd3; kj.cid = 64'hDEAD_BEEF_0012_3456;
        kj.plen = 8'd1; kj.pid = 64'hFFFF_FFFF_FFFF_FF5A;
        send_item(make_item(ntt_pkg::CMD_ADD, kj, 16'd30));
        kj.cid = 64'h0000_0000_0012_3456; kj.pid = 64'h5A;
        send_item(make_item(ntt_pkg::CMD_FIND, kj, 16'd0));
        kj.clen = 8'd2;
        send_item(make_item(ntt_pkg::CMD_FIND, kj, 16'd0));        // length differs
        kj = k; kj.clen = 8'd9;
        send_item(make_item(ntt_pkg::CMD_ADD, kj, 16'd1));
        kj = k; kj.plen = 8'hFF;
        send_item(make_item(ntt_pkg::CMD_FIND, kj, 16'd0));
        kj = k; kj.clen = 8'hFF; kj.plen = 8'hFF;
        send_item(make_item(ntt_pkg::CMD_ADD, kj, 16'd1));
        send_item(make_item(ntt_pkg::CMD_UNUSED, k, 16'd7));
        send_item(make_item(ntt_pkg::CMD_CLEANUP, kj, 16'd0));  // removes the wrapped one
        now_s = 32'hFFFF_FFFF;
        send_item(make_item(ntt_pkg::CMD_CLEANUP, k, 16'd0));
        now_s = 32'd0;
        send_item(make_item(ntt_pkg::CMD_FIND, k, 16'd0));
        send_item(make_item(ntt_pkg::CMD_CLEANUP, k, 16'd0));
        wait_drained();
    endtask

    task automatic test_table_full();
        t_key k;
        now_s = 32'd1000;
        for (int i = 0; i < DEPTH + 3; i++) begin
            k = rand_key(ID_MAX);
            send_item(make_item(ntt_pkg::CMD_ADD, k, 16'($urandom_range(1, 50))));
        end
        send_item(make_item(ntt_pkg::CMD_FIND, k, 16'd0));
        now_s = 32'd1025;
        send_item(make_item(ntt_pkg::CMD_CLEANUP, k, 16'd0));
        now_s = 32'd2000;
        send_item(make_item(ntt_pkg::CMD_CLEANUP, k, 16'd0));
        wait_drained();
    endtask

    task automatic test_random(input int count);
        t_key     k;
        ntt_pkg::t_in_item it;
        int       pick;
        now_s = $urandom_range(0, 1) ? $urandom : 32'hFFFF_F000;
        for (int i = 0; i < KEY_POOL; i++) keys[i] = rand_key(ID_MAX);
        for (int n = 0; n < count; n++) begin
            if (n == count - 200) quiet = 1'b1;
            if (n == count / 2) wait_drained();
            now_s += $urandom_range(0, 12);
            if ($urandom_range(0, 99) == 0) now_s += $urandom;
            k = keys[$urandom_range(0, KEY_POOL - 1)];
            // stray bytes past the length are don't-care in the key
            if ($urandom_range(0, 1)) begin
                k.cid ^= ~id_mask(k.clen) & {$urandom, $urandom};
                k.pid ^= ~id_mask(k.plen) & {$urandom, $urandom};
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                it = make_item(ntt_pkg::CMD_ADD, k, ($urandom_range(0, 19) == 0) ?
                               16'($urandom) : 16'($urandom_range(0, 120)));
            end else if (pick < 75) begin
                it = make_item(ntt_pkg::CMD_FIND, k, 16'($urandom));
            end else if (pick < 87) begin
                it = make_item(ntt_pkg::CMD_CLEANUP, k, 16'($urandom));
            end else if (pick < 95) begin
                if ($urandom_range(0, 1))
                    it = make_item(ntt_pkg::CMD_ADD, k, 16'($urandom));
                else
                    it = make_item(ntt_pkg::CMD_FIND, k, 16'($urandom));
                if ($urandom_range(0, 1)) it.chassis_length = 8'($urandom_range(9, 255));
                else it.port_length = 8'($urandom_range(9, 255));
            end else begin
                it = make_item(ntt_pkg::CMD_UNUSED, k, 16'($urandom));
            end
            if ($urandom_range(0, 9) == 0) it.now_seconds = $urandom;
            send_item(it);
            if (it.command == ntt_pkg::CMD_CLEANUP && $urandom_range(0, 9) == 0)
                keys[$urandom_range(0, KEY_POOL - 1)] = rand_key(ID_MAX);
        end
    endtask

    // result side: random ready bursts, compare against oldest prediction
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %p", o_item);
                n_errors++;
            end else begin
                ntt_pkg::t_out_item e;
                e = pending_results.pop_front();
                n_checked++;
                if (o_item.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_item.status);
                    n_errors++;
                end
                if (o_item.slot_index !== e.slot_index) begin
                    $error("slot_index: expected %0d actual %0d",
                           e.slot_index, o_item.slot_index);
                    n_errors++;
                end
                if (o_item.found_mac !== e.found_mac) begin
                    $error("found_mac: expected %h actual %h", e.found_mac, o_item.found_mac);
                    n_errors++;
                end
                if (o_item.found_ttl !== e.found_ttl) begin
                    $error("found_ttl: expected %0d actual %0d", e.found_ttl, o_item.found_ttl);
                    n_errors++;
                end
                if (o_item.found_expiry !== e.found_expiry) begin
                    $error("found_expiry: expected %h actual %h",
                           e.found_expiry, o_item.found_expiry);
                    n_errors++;
                end
                if (o_item.removed_count !== e.removed_count) begin
                    $error("removed_count: expected %0d actual %0d",
                           e.removed_count, o_item.removed_count);
                    n_errors++;
                end
                if (o_item.neighbor_count !== e.neighbor_count) begin
                    $error("neighbor_count: expected %0d actual %0d",
                           e.neighbor_count, o_item.neighbor_count);
                    n_errors++;
                end
            end
        end
        if (!i_rst_n || quiet) begin
            i_ready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= (stall_left == 1);
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 5);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) nb_valid[i] = 1'b0;
        nb_total = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(1650);
        wait_drained();
        $display("Checked %0d of %0d items: %0d finds hit, %0d table-full adds, %0d aged out.",
                 n_checked, n_sent, n_found, n_full, n_removed);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/ntt_pkg.sv
src/ntt_datapath.sv
src/ntt_ctrl.sv
src/neighbor_table_with_ttl_aging.sv
src/ntt_checker.sv
dv/neighbor_table_with_ttl_aging_tb.sv
